@@ design/sotq_pkg.sv @@
// Shared types and constants for the sorted timeout queue.
// No dependencies; every other design file refers to it by scoped name.
package sotq_pkg;

  localparam logic [1:0] MODE_ADD_SEC = 2'd0;
  localparam logic [1:0] MODE_ADD_MS  = 2'd1;
  localparam logic [1:0] MODE_SERVICE = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] KIND_ADDED    = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [1:0] KIND_REPORT   = 2'd3;

  localparam logic [30:0] RELOAD_MAX   = 31'h7FFFFFFF;
  localparam logic [31:0] FREQ_RESET   = 32'd62500000;
  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned REM_W        = 10;

  // divide by 1000 one 16-bit digit at a time; ceil(2^36 / 1000) is exact
  // for every partial dividend below 2^26
  localparam int unsigned DIV_CHUNK    = 16;
  localparam int unsigned DIV_SHIFT    = 36;
  localparam logic [26:0] DIV_RECIP    = 27'd68719477;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now_count;
    logic [31:0] delay_value;
    logic [15:0] timer_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] expired_tag;
    logic [30:0] reload_value;
    logic        irq_masked;
    logic [5:0]  pending;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] expiry;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } chain_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_INSERT,
    ST_REPORT,
    ST_POP
  } state_t;

endpackage

@@ design/sotq_cell.sv @@
// One cell of the sorted chain: holds one entry, shifts toward the tail on
// insert and toward the head on pop. Depends on sotq_pkg.
module sotq_cell (
  input  logic               clk,
  input  logic               rst,
  input  sotq_pkg::chain_ctl_t ctl,
  input  sotq_pkg::entry_t   new_ent,
  input  sotq_pkg::entry_t   prev_ent,
  input  logic               prev_le,
  input  sotq_pkg::entry_t   next_ent,
  output sotq_pkg::entry_t   ent,
  output logic               le
);

  sotq_pkg::entry_t ent_next;

  // entry sorts at or before the new one: the new one goes behind it
  assign le = ent.valid && (ent.expiry <= new_ent.expiry);

  always_comb begin
    ent_next = ent;
    if (ctl.pop) begin
      ent_next = next_ent;
    end else if (ctl.insert) begin
      if (!prev_le) begin
        ent_next = prev_ent;
      end else if (!le) begin
        ent_next = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.expiry <= ent_next.expiry;
    ent.tag    <= ent_next.tag;
  end

endmodule

@@ design/sotq_chain.sv @@
// Row of DEPTH sotq_cell instances kept in expiry order, head at cell 0.
// Depends on sotq_pkg and sotq_cell.
module sotq_chain #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sotq_pkg::chain_ctl_t ctl,
  input  sotq_pkg::entry_t     new_ent,
  output sotq_pkg::entry_t     head,
  output logic                 full
);

  sotq_pkg::entry_t ents [DEPTH];
  logic             les  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sotq_pkg::entry_t prev_ent;
    sotq_pkg::entry_t next_ent;
    logic             prev_le;

    if (i == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_le  = 1'b1;
    end else begin : g_mid
      assign prev_ent = ents[i-1];
      assign prev_le  = les[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end

    sotq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .new_ent  (new_ent),
      .prev_ent (prev_ent),
      .prev_le  (prev_le),
      .next_ent (next_ent),
      .ent      (ents[i]),
      .le       (les[i])
    );
  end

  assign head = ents[0];
  assign full = ents[DEPTH-1].valid;

endmodule

@@ design/sorted_timeout_queue_unit.sv @@
// Sorted timeout queue. After accepting, an add in seconds steps through MUL, ADD,
// INSERT and REPORT; an add in ms runs four 16-bit reciprocal-multiply divide steps
// between MUL and ADD; a full reject raises done at the accepting edge; a service gives
// one expired result per cycle, then the report. busy drops with the final strobe.
// Output is a one-cycle strobe; the receiver cannot stall. Synchronous reset clears
// the valid marks, count and state and sets freq to 62500000.
module sorted_timeout_queue_unit #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             start,
  input  sotq_pkg::req_t   req,
  output logic             busy,
  output logic             done,
  output sotq_pkg::rsp_t   rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = sotq_pkg::REM_W + sotq_pkg::DIV_CHUNK;
  localparam int PW = DW + 27;

  sotq_pkg::state_t     state, state_next;
  sotq_pkg::req_t       req_q;
  sotq_pkg::chain_ctl_t ctl;
  sotq_pkg::entry_t     head;
  sotq_pkg::entry_t     new_ent;
  sotq_pkg::rsp_t       rsp_next;

  logic [31:0]                     freq;
  logic [63:0]                     ticks;
  logic [63:0]                     prod;
  logic [sotq_pkg::REM_W-1:0]      rem;
  logic [DW-1:0]                   div_cur;
  logic [PW-1:0]                   div_prod;
  logic [sotq_pkg::DIV_CHUNK-1:0]  div_q;
  logic [DW-1:0]                   div_qm;
  logic [DW-1:0]                   div_rem;
  logic [1:0]                      chunk_cnt;
  logic [63:0]                     new_exp;
  logic [CW-1:0]                   count, count_next;
  logic                            done_next;
  logic                            full;
  logic                            head_due;
  logic [63:0]                     diff;
  logic [30:0]                     reload;
  logic                            accept;

  function automatic logic [5:0] pend6(input logic [CW-1:0] c);
    logic [CW+5:0] w;
    w = {6'b0, c};
    return w[5:0];
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state != sotq_pkg::ST_IDLE);
  assign prod    = 64'(req_q.delay_value) * 64'(freq);
  assign new_ent = '{valid: 1'b1, expiry: new_exp, tag: req_q.timer_tag};

  // one long-division digit: remainder and next 16 dividend bits over 1000
  assign div_cur  = {rem, ticks[63 -: sotq_pkg::DIV_CHUNK]};
  assign div_prod = PW'(div_cur) * PW'(sotq_pkg::DIV_RECIP);
  assign div_q    = div_prod[sotq_pkg::DIV_SHIFT +: sotq_pkg::DIV_CHUNK];
  assign div_qm   = DW'(div_q) * DW'(sotq_pkg::MS_PER_S);
  assign div_rem  = div_cur - div_qm;

  assign head_due = head.valid && (head.expiry <= req_q.now_count);
  assign diff     = head.expiry - req_q.now_count;

  always_comb begin
    if (!head.valid) begin
      reload = '0;
    end else if (head.expiry <= req_q.now_count) begin
      reload = 31'd1;
    end else if (diff[63:31] != '0) begin
      reload = sotq_pkg::RELOAD_MAX;
    end else begin
      reload = diff[30:0];
    end
  end

  sotq_chain #(.DEPTH(DEPTH)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .new_ent (new_ent),
    .head    (head),
    .full    (full)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    ctl        = '0;
    done_next  = 1'b0;
    rsp_next   = '0;
    case (state)
      sotq_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.mode)
            sotq_pkg::MODE_ADD_SEC, sotq_pkg::MODE_ADD_MS: begin
              if (full) begin
                done_next        = 1'b1;
                rsp_next.kind    = sotq_pkg::KIND_REJECTED;
                rsp_next.pending = pend6(count);
                rsp_next.last    = 1'b1;
              end else begin
                state_next = sotq_pkg::ST_MUL;
              end
            end
            sotq_pkg::MODE_SERVICE: state_next = sotq_pkg::ST_POP;
            default:                state_next = sotq_pkg::ST_IDLE;
          endcase
        end
      end
      sotq_pkg::ST_MUL: begin
        state_next = (req_q.mode == sotq_pkg::MODE_ADD_MS) ? sotq_pkg::ST_DIV
                                                            : sotq_pkg::ST_ADD;
      end
      sotq_pkg::ST_DIV: begin
        if (chunk_cnt == 2'd3) begin
          state_next = sotq_pkg::ST_ADD;
        end
      end
      sotq_pkg::ST_ADD: state_next = sotq_pkg::ST_INSERT;
      sotq_pkg::ST_INSERT: begin
        ctl.insert = 1'b1;
        count_next = count + CW'(1);
        state_next = sotq_pkg::ST_REPORT;
      end
      sotq_pkg::ST_REPORT: begin
        done_next             = 1'b1;
        rsp_next.kind         = sotq_pkg::KIND_ADDED;
        rsp_next.reload_value = reload;
        rsp_next.irq_masked   = (count == '0);
        rsp_next.pending      = pend6(count);
        rsp_next.last         = 1'b1;
        state_next            = sotq_pkg::ST_IDLE;
      end
      sotq_pkg::ST_POP: begin
        done_next = 1'b1;
        if (head_due) begin
          ctl.pop              = 1'b1;
          count_next           = count - CW'(1);
          rsp_next.kind        = sotq_pkg::KIND_EXPIRED;
          rsp_next.expired_tag = head.tag;
          rsp_next.irq_masked  = (count_next == '0);
          rsp_next.pending     = pend6(count_next);
        end else begin
          rsp_next.kind         = sotq_pkg::KIND_REPORT;
          rsp_next.reload_value = reload;
          rsp_next.irq_masked   = (count == '0);
          rsp_next.pending      = pend6(count);
          rsp_next.last         = 1'b1;
          state_next            = sotq_pkg::ST_IDLE;
        end
      end
      default: state_next = sotq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sotq_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
      freq  <= sotq_pkg::FREQ_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_we) begin
        freq <= cfg_wdata;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (accept) begin
      req_q <= req;
    end
    case (state)
      sotq_pkg::ST_MUL: begin
        ticks     <= prod;
        rem       <= '0;
        chunk_cnt <= '0;
      end
      sotq_pkg::ST_DIV: begin
        // radix-2^16 long division, quotient digits shift in behind the dividend
        ticks     <= {ticks[63-sotq_pkg::DIV_CHUNK:0], div_q};
        rem       <= div_rem[sotq_pkg::REM_W-1:0];
        chunk_cnt <= chunk_cnt + 2'd1;
      end
      sotq_pkg::ST_ADD: new_exp <= req_q.now_count + ticks;
      default: ;
    endcase
  end

endmodule

@@ design/sotq_checker.sv @@
// Port-level checks for sorted_timeout_queue_unit, bound to every instance.
// Depends on sotq_pkg and the top level's ports.
module sotq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input sotq_pkg::req_t req,
  input logic           done,
  input sotq_pkg::rsp_t rsp
);

  // expirations come back to back and always end in the report
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |=> done)
    else $error("expired result not followed by another result");

  a_not_last_is_expired: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |-> rsp.kind == sotq_pkg::KIND_EXPIRED)
    else $error("non-final result of wrong kind");

  a_no_reload: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.kind == sotq_pkg::KIND_EXPIRED || rsp.kind == sotq_pkg::KIND_REJECTED)
    |-> rsp.reload_value == '0)
    else $error("reload on expired or rejected result");

  a_masked_empty: assert property (@(posedge clk) disable iff (rst)
    done && rsp.irq_masked |-> rsp.pending == '0 && rsp.reload_value == '0)
    else $error("masked with entries pending");

  a_ignored_mode: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.mode == sotq_pkg::MODE_NONE |=> !done && !busy)
    else $error("ignored request produced a result");

endmodule

bind sorted_timeout_queue_unit sotq_checker u_sotq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
